[sv/rrst_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rrst_pkg
// Types and constants for the 2D ray / rectangle slab test.
// ----------------------------------------------------------------------------
package rrst_pkg;

   localparam int ValueBits = 32;
   localparam int FracBits  = 16;
   localparam int DistBits  = 31;
   localparam int EpsBits   = 16;
   // numerator width: 33-bit difference magnitude shifted by the fraction bits
   localparam int NumBits   = ValueBits + 1 + FracBits;
   localparam int MagBits   = ValueBits + 1;
   localparam logic [EpsBits-1:0] EpsReset = EpsBits'(1);

   typedef struct packed {
      logic signed [ValueBits-1:0] pos_x;
      logic signed [ValueBits-1:0] pos_y;
      logic signed [ValueBits-1:0] dir_x;
      logic signed [ValueBits-1:0] dir_y;
      logic signed [ValueBits-1:0] rect_min_x;
      logic signed [ValueBits-1:0] rect_min_y;
      logic signed [ValueBits-1:0] rect_max_x;
      logic signed [ValueBits-1:0] rect_max_y;
   } req_type;

   typedef struct packed {
      logic                hit;
      logic [DistBits-1:0] distance;
   } rsp_type;

endpackage
`default_nettype wire

[sv/rrst_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rrst_div
// Pipelined restoring divider: four slab numerators over two divisors, one per
// axis, one quotient bit per stage, then saturation to the signed value range.
// ----------------------------------------------------------------------------
module rrst_div
   import rrst_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire logic                  in_valid,
   input  wire logic [3:0][NumBits-1:0] in_num,
   input  wire logic [3:0]            in_nneg,
   input  wire logic [1:0][MagBits-1:0] in_dmag,
   input  wire logic [1:0]            in_dneg,
   input  wire logic [1:0]            in_par,
   input  wire logic [1:0]            in_inside,
   output logic                       out_valid,
   output logic [3:0][ValueBits-1:0]  out_t,
   output logic [1:0]                 out_par,
   output logic [1:0]                 out_inside
);

   localparam int Steps = NumBits;

   // one entry per stage, each stage written by its own block
   logic                      vld_ff  [Steps+1];
   logic [3:0][NumBits-1:0]   rem_ff  [Steps+1];
   logic [3:0][NumBits-1:0]   num_ff  [Steps+1];
   logic [3:0][NumBits-1:0]   quo_ff  [Steps+1];
   logic [3:0]                nneg_ff [Steps+1];
   logic [1:0][MagBits-1:0]   dmag_ff [Steps+1];
   logic [1:0]                dneg_ff [Steps+1];
   logic [1:0]                par_ff  [Steps+1];
   logic [1:0]                ins_ff  [Steps+1];

   // stage 0 loads the operands
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
      end
      if (adv) begin
         num_ff[0]  <= in_num;
         rem_ff[0]  <= '0;
         quo_ff[0]  <= '0;
         nneg_ff[0] <= in_nneg;
         dmag_ff[0] <= in_dmag;
         dneg_ff[0] <= in_dneg;
         par_ff[0]  <= in_par;
         ins_ff[0]  <= in_inside;
      end
   end

   // one quotient bit per stage
   for (genvar s = 0; s < Steps; s++) begin : g_step
      logic [3:0][NumBits-1:0] rem_in;
      logic [3:0][NumBits-1:0] quo_in;
      always_comb begin
         for (int k = 0; k < 4; k++) begin
            logic [NumBits:0] trial;
            trial = {rem_ff[s][k], num_ff[s][k][NumBits-1-s]};
            if (trial >= {{(NumBits+1-MagBits){1'b0}}, dmag_ff[s][k/2]}) begin
               trial = trial - {{(NumBits+1-MagBits){1'b0}}, dmag_ff[s][k/2]};
               quo_in[k] = {quo_ff[s][k][NumBits-2:0], 1'b1};
            end else begin
               quo_in[k] = {quo_ff[s][k][NumBits-2:0], 1'b0};
            end
            rem_in[k] = trial[NumBits-1:0];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[s+1] <= vld_ff[s];
         end
         if (adv) begin
            rem_ff[s+1]  <= rem_in;
            quo_ff[s+1]  <= quo_in;
            num_ff[s+1]  <= num_ff[s];
            nneg_ff[s+1] <= nneg_ff[s];
            dmag_ff[s+1] <= dmag_ff[s];
            dneg_ff[s+1] <= dneg_ff[s];
            par_ff[s+1]  <= par_ff[s];
            ins_ff[s+1]  <= ins_ff[s];
         end
      end
   end

   // saturate and apply sign
   logic [3:0][ValueBits-1:0] t_in;
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         logic              neg;
         logic [NumBits-1:0] q;
         logic [ValueBits-1:0] lim;
         neg = nneg_ff[Steps][k] ^ dneg_ff[Steps][k/2];
         q   = quo_ff[Steps][k];
         lim = neg ? {1'b1, {(ValueBits-1){1'b0}}} : {1'b0, {(ValueBits-1){1'b1}}};
         if (q > {{(NumBits-ValueBits){1'b0}}, lim}) begin
            q = {{(NumBits-ValueBits){1'b0}}, lim};
         end
         t_in[k] = neg ? (ValueBits'(0) - q[ValueBits-1:0]) : q[ValueBits-1:0];
      end
   end

   logic                       ovld_ff;
   logic [3:0][ValueBits-1:0]  t_ff;
   logic [1:0]                 opar_ff;
   logic [1:0]                 oins_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         ovld_ff <= 1'b0;
      end else if (adv) begin
         ovld_ff <= vld_ff[Steps];
      end
      if (adv) begin
         t_ff    <= t_in;
         opar_ff <= par_ff[Steps];
         oins_ff <= ins_ff[Steps];
      end
   end

   assign out_valid  = ovld_ff;
   assign out_t      = t_ff;
   assign out_par    = opar_ff;
   assign out_inside = oins_ff;

endmodule
`default_nettype wire

[sv/ray_rectangle_slab_test.sv]
`default_nettype none
// Pipeline: front end, divider operand stage, 49 divider quotient stages,
// saturation, interval stage, output register.
// Throughput: one request per cycle; the pipeline advances whenever its output
// register is empty or being taken.
// Reset: synchronous, clears all valid bits and sets parallel_epsilon to 1.
// ----------------------------------------------------------------------------
// ray_rectangle_slab_test
// 2D ray versus axis-aligned rectangle slab test in signed Q16.16.
// ----------------------------------------------------------------------------
module ray_rectangle_slab_test
   import rrst_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write,
   input  wire logic [EpsBits-1:0] csr_wdata,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rsp_type                 rsp_data
);

   logic [EpsBits-1:0] eps_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EpsReset;
      end else if (csr_write) begin
         eps_ff <= csr_wdata;
      end
   end

   logic adv;
   logic ovld_ff;
   assign adv       = !ovld_ff || !rsp_stall;
   assign req_stall = !adv;

   // front end: differences, magnitudes, parallel flags
   logic [1:0][ValueBits-1:0] p, d, mn, mx;
   assign p[0]  = req_data.pos_x;       assign p[1]  = req_data.pos_y;
   assign d[0]  = req_data.dir_x;       assign d[1]  = req_data.dir_y;
   assign mn[0] = req_data.rect_min_x;  assign mn[1] = req_data.rect_min_y;
   assign mx[0] = req_data.rect_max_x;  assign mx[1] = req_data.rect_max_y;

   logic [3:0][NumBits-1:0]   f_num;
   logic [3:0]                f_nneg;
   logic [1:0][MagBits-1:0]   f_dmag;
   logic [1:0]                f_dneg, f_par, f_ins;
   always_comb begin
      for (int a = 0; a < 2; a++) begin
         logic signed [MagBits-1:0] dl, dh, ds;
         logic [MagBits-1:0] ml, mh;
         dl = MagBits'(signed'(mn[a])) - MagBits'(signed'(p[a]));
         dh = MagBits'(signed'(mx[a])) - MagBits'(signed'(p[a]));
         ds = MagBits'(signed'(d[a]));
         ml = dl[MagBits-1] ? MagBits'(0) - dl : dl;
         mh = dh[MagBits-1] ? MagBits'(0) - dh : dh;
         f_num[2*a]    = {ml, {FracBits{1'b0}}};
         f_num[2*a+1]  = {mh, {FracBits{1'b0}}};
         f_nneg[2*a]   = dl[MagBits-1];
         f_nneg[2*a+1] = dh[MagBits-1];
         f_dneg[a]     = ds[MagBits-1];
         f_dmag[a]     = ds[MagBits-1] ? MagBits'(0) - ds : ds;
         f_par[a]      = (f_dmag[a] == '0) ||
                         (f_dmag[a] < {{(MagBits-EpsBits){1'b0}}, eps_ff});
         f_ins[a]      = (signed'(p[a]) >= signed'(mn[a])) &&
                         (signed'(p[a]) <= signed'(mx[a]));
      end
   end

   logic                      fv_ff;
   logic [3:0][NumBits-1:0]   num_ff;
   logic [3:0]                nneg_ff;
   logic [1:0][MagBits-1:0]   dmag_ff;
   logic [1:0]                dneg_ff, par_ff, ins_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
      end else if (adv) begin
         fv_ff <= req_valid;
      end
      if (adv) begin
         num_ff  <= f_num;
         nneg_ff <= f_nneg;
         // parallel axes use divisor 1 to keep the divider well defined
         for (int a = 0; a < 2; a++) begin
            dmag_ff[a] <= f_par[a] ? MagBits'(1) : f_dmag[a];
         end
         dneg_ff <= f_dneg;
         par_ff  <= f_par;
         ins_ff  <= f_ins;
      end
   end

   logic                      dv;
   logic [3:0][ValueBits-1:0] t;
   logic [1:0]                dpar, dins;
   rrst_div u_div (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (fv_ff),
      .in_num     (num_ff),
      .in_nneg    (nneg_ff),
      .in_dmag    (dmag_ff),
      .in_dneg    (dneg_ff),
      .in_par     (par_ff),
      .in_inside  (ins_ff),
      .out_valid  (dv),
      .out_t      (t),
      .out_par    (dpar),
      .out_inside (dins)
   );

   // order slab parameters and intersect per axis
   logic signed [ValueBits-1:0] lo0, hi0, lo1, hi1;
   logic                        miss_in;
   logic signed [ValueBits-1:0] ent_in, ext_in;
   always_comb begin
      lo0 = (signed'(t[0]) > signed'(t[1])) ? t[1] : t[0];
      hi0 = (signed'(t[0]) > signed'(t[1])) ? t[0] : t[1];
      lo1 = (signed'(t[2]) > signed'(t[3])) ? t[3] : t[2];
      hi1 = (signed'(t[2]) > signed'(t[3])) ? t[2] : t[3];
      ent_in  = '0;
      ext_in  = {1'b0, {(ValueBits-1){1'b1}}};
      miss_in = 1'b0;
      if (dpar[0]) begin
         miss_in = !dins[0];
      end else begin
         if (lo0 > ent_in) ent_in = lo0;
         if (hi0 < ext_in) ext_in = hi0;
      end
      if (dpar[1]) begin
         miss_in = miss_in || !dins[1];
      end else begin
         if (lo1 > ent_in) ent_in = lo1;
         if (hi1 < ext_in) ext_in = hi1;
      end
   end

   logic                        iv_ff, miss_ff;
   logic signed [ValueBits-1:0] ent_ff, ext_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         iv_ff <= 1'b0;
      end else if (adv) begin
         iv_ff <= dv;
      end
      if (adv) begin
         miss_ff <= miss_in;
         ent_ff  <= ent_in;
         ext_ff  <= ext_in;
      end
   end

   // hit decision and output register
   rsp_type rsp_in;
   always_comb begin
      rsp_in.hit      = !miss_ff && !(ent_ff > ext_ff);
      rsp_in.distance = rsp_in.hit ? ent_ff[DistBits-1:0] : '0;
   end

   rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         ovld_ff <= 1'b0;
      end else if (adv) begin
         ovld_ff <= iv_ff;
      end
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = ovld_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire
